// ----- rtl/clq_pkg.sv -----
// Package: shared constants and types for the circular linked queue manager.
`timescale 1ns / 1ps

package clq_pkg;

    localparam int CLQ_NUM_NODES = 16;
    localparam int NODE_W        = 4;
    localparam int CNT_W         = 5;
    localparam int STATUS_W      = 2;

    typedef enum logic {
        FUNC_APPEND = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_LINKED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [CNT_W-1:0]    queue_count;
        logic [NODE_W-1:0]   head_node;
        logic                queue_empty;
    } t_result;

endpackage

// ----- rtl/clq_in_if.sv -----
// Interface: request channel (operation and node number).
`timescale 1ns / 1ps

interface clq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [clq_pkg::NODE_W-1:0]  node_index;

    modport source (output valid, func, node_index, input ready);
    modport sink   (input valid, func, node_index, output ready);
endinterface

// ----- rtl/clq_out_if.sv -----
// Interface: result channel (status, size, head, empty flag).
`timescale 1ns / 1ps

interface clq_out_if;
    logic                          valid;
    logic                          ready;
    logic [clq_pkg::STATUS_W-1:0]  status;
    logic [clq_pkg::CNT_W-1:0]     queue_count;
    logic [clq_pkg::NODE_W-1:0]    head_node;
    logic                          queue_empty;

    modport source (output valid, status, queue_count, head_node, queue_empty, input ready);
    modport sink   (input valid, status, queue_count, head_node, queue_empty, output ready);
endinterface

// ----- rtl/clq_core.sv -----
// Queue state (links, membership, head, tail, count) and combinational next-state update.
`timescale 1ns / 1ps

module clq_core #(
    parameter int NUM_NODES = clq_pkg::CLQ_NUM_NODES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_func,
    input  logic [clq_pkg::NODE_W-1:0]  i_node,
    output clq_pkg::t_result            o_result
);

    localparam int LW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int CW = clq_pkg::CNT_W;
    localparam int NW = clq_pkg::NODE_W;

    logic [LW-1:0]        r_next [NUM_NODES];
    logic [LW-1:0]        r_prev [NUM_NODES];
    logic [LW-1:0]        n_next [NUM_NODES];
    logic [LW-1:0]        n_prev [NUM_NODES];
    logic [NUM_NODES-1:0] r_member, n_member;
    logic [LW-1:0]        r_head, n_head;
    logic [LW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_count, n_count;

    logic                 w_in_range;
    logic                 w_is_member;
    logic                 w_empty;
    logic [LW-1:0]        w_node;
    logic [LW-1:0]        w_nx;
    logic [LW-1:0]        w_pv;
    clq_pkg::t_status     w_status;

    assign w_in_range  = 32'(i_node) < NUM_NODES;
    assign w_node      = LW'(i_node);
    assign w_is_member = w_in_range && r_member[w_node];
    assign w_empty     = (r_count == '0);
    assign w_nx        = r_next[w_node];
    assign w_pv        = r_prev[w_node];

    // Tail is kept in a register so an append needs no link read.
    always_comb begin
        n_next   = r_next;
        n_prev   = r_prev;
        n_member = r_member;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        w_status = clq_pkg::ST_OK;
        if (i_func == clq_pkg::FUNC_APPEND) begin
            if (!w_in_range) begin
                w_status = clq_pkg::ST_ABSENT;
            end else if (w_is_member) begin
                w_status = clq_pkg::ST_LINKED;
            end else begin
                if (w_empty) begin
                    n_next[w_node] = w_node;
                    n_prev[w_node] = w_node;
                    n_head         = w_node;
                end else begin
                    n_next[w_node] = r_head;
                    n_prev[w_node] = r_tail;
                    n_next[r_tail] = w_node;
                    n_prev[r_head] = w_node;
                end
                n_tail           = w_node;
                n_member[w_node] = 1'b1;
                n_count          = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                w_status = clq_pkg::ST_EMPTY;
            end else if (!w_is_member) begin
                w_status = clq_pkg::ST_ABSENT;
            end else begin
                if (r_count == CW'(1)) begin
                    n_head = '0;
                end else begin
                    // Links of the removed node are dead; never read while unlinked.
                    n_next[w_pv] = w_nx;
                    n_prev[w_nx] = w_pv;
                    if (r_head == w_node) begin
                        n_head = w_nx;
                    end
                    if (r_tail == w_node) begin
                        n_tail = w_pv;
                    end
                end
                n_member[w_node] = 1'b0;
                n_count          = r_count - CW'(1);
            end
        end
    end

    always_comb begin
        o_result.status      = w_status;
        o_result.queue_count = n_count;
        o_result.queue_empty = (n_count == '0);
        o_result.head_node   = (n_count == '0) ? '0 : NW'(n_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
        end else if (i_en) begin
            r_member <= n_member;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_next <= n_next;
            r_prev <= n_prev;
        end
    end

    a_count_matches_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_member) == int'(r_count))
        else $error("count differs from number of member nodes");

    a_head_is_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_member[r_head] && r_member[r_tail]))
        else $error("head or tail not a member");

    a_ring_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_next[r_tail] == r_head && r_prev[r_head] == r_tail))
        else $error("tail and head not linked");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_func == clq_pkg::FUNC_APPEND && w_status == clq_pkg::ST_OK)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted append did not grow the queue");

    a_refused_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_status != clq_pkg::ST_OK) |=> ($stable(r_member) && $stable(r_count)))
        else $error("refused operation changed the queue");

endmodule

// ----- rtl/circular_linked_queue_manager.sv -----
// Top level: circular doubly linked queue manager with registered result channel.
`timescale 1ns / 1ps

//  channel | dir | payload                                         | transfer when
//  --------+-----+-------------------------------------------------+---------------
//  i_in    | in  | func, node_index                                | valid && ready
//  o_out   | out | status, queue_count, head_node, queue_empty     | valid && ready
//
//  One request per cycle while i_in.ready is high; the result is registered for the cycle after the transfer.
//  Each operation touches at most four link entries plus head/tail/count,
//  all in flops, so the whole update fits between request and result register.
//  i_in.ready drops while in reset, or while a result waits and o_out.ready is low.
//  Synchronous active-low reset empties the queue; link contents are don't-care.

module circular_linked_queue_manager #(
    parameter int NUM_NODES = clq_pkg::CLQ_NUM_NODES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clq_in_if.sink     i_in,
    clq_out_if.source  o_out
);

    logic             w_accept;
    logic             r_out_valid;
    clq_pkg::t_result w_result;
    clq_pkg::t_result r_result;

    // Output register frees up whenever the sink takes the held result.
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    clq_core #(
        .NUM_NODES (NUM_NODES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_accept),
        .i_func   (i_in.func),
        .i_node   (i_in.node_index),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_result.status;
    assign o_out.queue_count = r_result.queue_count;
    assign o_out.head_node   = r_result.head_node;
    assign o_out.queue_empty = r_result.queue_empty;

endmodule
